[hdl/ffch_pkg.sv]
`default_nettype none

package ffch_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOMEM    = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_NOTALLOC = 3'd3;
  localparam logic [2:0] ST_NULL     = 3'd4;

  // Request kinds.
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Datapath operations issued by the controller, at most one per cycle.
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_INIT0  = 5'd1;
  localparam logic [4:0] OP_INIT1  = 5'd2;
  localparam logic [4:0] OP_LOAD   = 5'd3;
  localparam logic [4:0] OP_DIV    = 5'd4;
  localparam logic [4:0] OP_ACHK   = 5'd5;
  localparam logic [4:0] OP_AWALK  = 5'd6;
  localparam logic [4:0] OP_TAKE   = 5'd7;
  localparam logic [4:0] OP_TAKE2  = 5'd8;
  localparam logic [4:0] OP_RCHK   = 5'd9;
  localparam logic [4:0] OP_RRD    = 5'd10;
  localparam logic [4:0] OP_PREW   = 5'd11;
  localparam logic [4:0] OP_ISTART = 5'd12;
  localparam logic [4:0] OP_IWALK  = 5'd13;
  localparam logic [4:0] OP_IMERGE = 5'd14;
  localparam logic [4:0] OP_IDEC   = 5'd15;
  localparam logic [4:0] OP_IFWD   = 5'd16;
  localparam logic [4:0] OP_IWB    = 5'd17;
  localparam logic [4:0] OP_IWB2   = 5'd18;
  localparam logic [4:0] OP_EMIT   = 5'd19;

  typedef struct packed {
    logic        kind;
    logic [11:0] request_bytes;
    logic [11:0] release_offset;
  } ffch_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] payload_offset;
    logic [11:0] free_bytes;
    logic [11:0] min_free_bytes;
    logic [31:0] alloc_count;
    logic [31:0] release_count;
  } ffch_rsp_t;

  typedef struct packed {
    logic [4:0] op;
  } ffch_ctl_t;

  typedef struct packed {
    logic is_rel;
    logic zero;
    logic no_room;
    logic rel_bad;
    logic walk_go;
    logic walk_fit;
    logic split;
    logic rel_ok;
    logic ins_first;
    logic ins_go;
    logic fwd;
    logic link_prev;
    logic out_free;
  } ffch_sts_t;

endpackage

`default_nettype wire

[hdl/first_fit_coalescing_heap.sv]
// A zero or oversized allocate and a null or misaligned release end without reading a
// header; a granted allocate walks the free list, and a split remainder or a good
// release is put back by a second walk that merges it with free neighbours.
// One word at a time; the next is taken the cycle after its result is queued.
// Reset is synchronous; the first block and end marker headers are written after it.
`default_nettype none

module first_fit_coalescing_heap
  import ffch_pkg::*;
#(
  parameter int HEAP_BYTES  = 4096,
  parameter int ALIGN_BYTES = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire ffch_cmd_t cmd,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output ffch_rsp_t      rsp
);

  // The controller sequences each request word through the header memory,
  // one operation per cycle. The datapath holds the heap bookkeeping: the
  // list head, free counts, operation counters and the header memory itself.
  // A result word sits in an output register so a new request can be taken
  // while the previous result is still waiting to be read.

  ffch_ctl_t ctl;
  ffch_sts_t sts;

  ffch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  ffch_dp #(
    .HEAP_BYTES (HEAP_BYTES),
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .ctl      (ctl),
    .sts      (sts),
    .rsp_stall(rsp_stall),
    .rsp_valid(rsp_valid),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

[hdl/ffch_ram.sv]
`default_nettype none

module ffch_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hdl/ffch_ctrl.sv]
`default_nettype none

module ffch_ctrl
  import ffch_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire ffch_sts_t sts,
  output ffch_ctl_t      ctl
);

  localparam logic [4:0] S_INIT0  = 5'd0;
  localparam logic [4:0] S_INIT1  = 5'd1;
  localparam logic [4:0] S_IDLE   = 5'd2;
  localparam logic [4:0] S_DIV    = 5'd3;
  localparam logic [4:0] S_ACHK   = 5'd4;
  localparam logic [4:0] S_AWALK  = 5'd5;
  localparam logic [4:0] S_TAKE   = 5'd6;
  localparam logic [4:0] S_TAKE2  = 5'd7;
  localparam logic [4:0] S_RCHK   = 5'd8;
  localparam logic [4:0] S_RRD    = 5'd9;
  localparam logic [4:0] S_PREW   = 5'd10;
  localparam logic [4:0] S_ISTART = 5'd11;
  localparam logic [4:0] S_IWALK  = 5'd12;
  localparam logic [4:0] S_IMERGE = 5'd13;
  localparam logic [4:0] S_IDEC   = 5'd14;
  localparam logic [4:0] S_IFWD   = 5'd15;
  localparam logic [4:0] S_IWB    = 5'd16;
  localparam logic [4:0] S_IWB2   = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  logic [4:0] state;
  logic [4:0] state_next;

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    unique case (state)
      S_INIT0: begin
        ctl.op     = OP_INIT0;
        state_next = S_INIT1;
      end
      S_INIT1: begin
        ctl.op     = OP_INIT1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.op     = OP_LOAD;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        ctl.op     = OP_DIV;
        state_next = sts.is_rel ? S_RCHK : S_ACHK;
      end
      S_ACHK: begin
        ctl.op     = OP_ACHK;
        state_next = (sts.zero || sts.no_room) ? S_DONE : S_AWALK;
      end
      S_AWALK: begin
        ctl.op = OP_AWALK;
        if (sts.walk_go) begin
          state_next = S_AWALK;
        end else if (sts.walk_fit) begin
          state_next = S_TAKE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TAKE: begin
        ctl.op     = OP_TAKE;
        state_next = S_TAKE2;
      end
      S_TAKE2: begin
        ctl.op     = OP_TAKE2;
        state_next = sts.split ? S_PREW : S_DONE;
      end
      S_RCHK: begin
        ctl.op     = OP_RCHK;
        state_next = (sts.zero || sts.rel_bad) ? S_DONE : S_RRD;
      end
      S_RRD: begin
        ctl.op     = OP_RRD;
        state_next = sts.rel_ok ? S_PREW : S_DONE;
      end
      S_PREW: begin
        ctl.op     = OP_PREW;
        state_next = S_ISTART;
      end
      S_ISTART: begin
        ctl.op     = OP_ISTART;
        state_next = sts.ins_first ? S_IWALK : S_IMERGE;
      end
      S_IWALK: begin
        ctl.op     = OP_IWALK;
        state_next = sts.ins_go ? S_IWALK : S_IMERGE;
      end
      S_IMERGE: begin
        ctl.op     = OP_IMERGE;
        state_next = S_IDEC;
      end
      S_IDEC: begin
        ctl.op     = OP_IDEC;
        state_next = sts.fwd ? S_IFWD : S_IWB;
      end
      S_IFWD: begin
        ctl.op     = OP_IFWD;
        state_next = S_IWB;
      end
      S_IWB: begin
        ctl.op     = OP_IWB;
        state_next = sts.link_prev ? S_IWB2 : S_DONE;
      end
      S_IWB2: begin
        ctl.op     = OP_IWB2;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
    end else begin
      state <= state_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid) |=> (state == S_DIV))
    else $error("accepted word did not start processing");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !sts.out_free) |=> (state == S_DONE))
    else $error("result dropped while output register busy");

  a_walk_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_AWALK) |-> ($past(state) == S_ACHK || $past(state) == S_AWALK))
    else $error("list walk entered from an unexpected state");

  a_link_after_wb: assert property (@(posedge clk) disable iff (rst)
    (state == S_IWB2) |-> ($past(state) == S_IWB))
    else $error("predecessor link written out of order");

endmodule

`default_nettype wire

[hdl/ffch_dp.sv]
`default_nettype none

module ffch_dp
  import ffch_pkg::*;
#(
  parameter int HEAP_BYTES  = 4096,
  parameter int ALIGN_BYTES = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ffch_cmd_t cmd,
  input  wire ffch_ctl_t ctl,
  output ffch_sts_t      sts,
  input  wire logic      rsp_stall,
  output logic           rsp_valid,
  output ffch_rsp_t      rsp
);

  localparam int HDR_BYTES = ((8 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int HDR_GR    = HDR_BYTES / ALIGN_BYTES;
  localparam int GRANULES  = HEAP_BYTES / ALIGN_BYTES;
  localparam int END_GR    = (HEAP_BYTES - HDR_BYTES) / ALIGN_BYTES;
  localparam int GW        = $clog2(GRANULES);
  localparam int BW        = $clog2(HEAP_BYTES + 1);
  localparam int HW        = 2 * GW + 2;
  // Quotient operands stay below 2^QN; reciprocal multiply is exact for them.
  localparam int QN        = 13;
  localparam int DL        = $clog2(ALIGN_BYTES);
  localparam int DS        = QN + DL;
  localparam int MW        = DS - DL + 2;
  localparam int DIV_MUL   = ((1 << DS) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int CW        = ((GW > QN) ? GW : QN) + 1;
  localparam int WW        = (BW > QN + DL + 1) ? BW : QN + DL + 1;

  localparam logic [GW-1:0] END_IX    = GW'(END_GR);
  localparam logic [GW-1:0] SPLIT_GR  = GW'(2 * HDR_GR);
  localparam logic [BW-1:0] END_BYTES = BW'(END_GR * ALIGN_BYTES);

  typedef struct packed {
    logic [GW-1:0] size;
    logic          alloc;
    logic [GW-1:0] next;
    logic          nul;
  } hdr_t;

  function automatic logic [QN-1:0] div_align(input logic [QN-1:0] x);
    logic [QN+MW-1:0] p;
    p = (QN + MW)'(x) * (QN + MW)'(DIV_MUL);
    return QN'(p >> DS);
  endfunction

  function automatic logic [BW-1:0] gran_bytes(input logic [GW-1:0] n);
    return BW'(BW'(n) * BW'(ALIGN_BYTES));
  endfunction

  // Header memory port signals.
  logic          wr_en;
  logic [GW-1:0] wr_addr;
  hdr_t          wr_hdr;
  logic [GW-1:0] rd_addr;
  logic [HW-1:0] rd_data;
  hdr_t          rd_hdr;

  // Control registers.
  logic [GW-1:0] list_head;
  logic [BW-1:0] free_cnt;
  logic [BW-1:0] min_cnt;
  logic [31:0]   alloc_cnt;
  logic [31:0]   rel_cnt;

  // Working registers.
  logic          kind_r;
  logic [11:0]   req_r;
  logic [11:0]   rel_r;
  logic [QN-1:0] q;
  logic [2:0]    res_status;
  logic [11:0]   res_payload;
  logic [GW-1:0] a_blk;
  logic [GW-1:0] a_prev;
  logic          a_prev_start;
  hdr_t          a_hdr;
  hdr_t          a_prev_hdr;
  logic [GW-1:0] i_blk;
  hdr_t          i_bh;
  logic [GW-1:0] i_it;
  logic          i_it_start;
  hdr_t          i_it_hdr;
  logic          i_merged;
  logic [GW-1:0] i_nx;

  // Derived values.
  logic [WW-1:0] q_bytes;
  logic [GW-1:0] rel_gran;
  logic [GW-1:0] a_diff;
  logic [GW-1:0] a_fsize;
  logic          back;
  logic [GW-1:0] ins_nx;

  assign rd_hdr   = rd_data;
  assign q_bytes  = WW'(WW'(q) * WW'(ALIGN_BYTES));
  assign rel_gran = GW'(q - QN'(HDR_GR));
  assign a_diff   = a_hdr.size - GW'(q);
  assign a_fsize  = sts.split ? GW'(q) : a_hdr.size;
  assign back     = !i_it_start &&
                    ((GW + 1)'(i_it) + (GW + 1)'(i_it_hdr.size) == (GW + 1)'(i_blk));
  assign ins_nx   = i_it_start ? list_head : i_it_hdr.next;

  ffch_ram #(
    .WIDTH(HW),
    .DEPTH(GRANULES)
  ) u_hdr_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_hdr),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    sts.is_rel    = (kind_r == KIND_RELEASE);
    sts.zero      = (kind_r == KIND_RELEASE) ? (rel_r == 12'd0) : (req_r == 12'd0);
    sts.no_room   = q_bytes > WW'(free_cnt);
    sts.rel_bad   = (rel_r < 12'(HDR_BYTES)) || (q_bytes != WW'(rel_r)) ||
                    (CW'(q) - CW'(HDR_GR) >= CW'(END_GR));
    sts.walk_go   = (CW'(rd_hdr.size) < CW'(q)) && !rd_hdr.nul;
    sts.walk_fit  = (a_blk < END_IX) && (CW'(rd_hdr.size) >= CW'(q));
    sts.split     = a_diff > SPLIT_GR;
    sts.rel_ok    = rd_hdr.alloc && rd_hdr.nul;
    sts.ins_first = list_head < i_blk;
    sts.ins_go    = rd_hdr.next < i_blk;
    sts.fwd       = ((GW + 1)'(i_blk) + (GW + 1)'(i_bh.size) == (GW + 1)'(i_nx)) &&
                    (i_nx != END_IX);
    sts.link_prev = !i_merged && !i_it_start;
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    rd_addr = list_head;
    wr_en   = 1'b0;
    wr_addr = a_blk;
    wr_hdr  = '0;
    unique case (ctl.op)
      OP_INIT0: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_hdr  = {END_IX, 1'b0, END_IX, 1'b0};
      end
      OP_INIT1: begin
        wr_en   = 1'b1;
        wr_addr = END_IX;
        wr_hdr  = {GW'(0), 1'b0, GW'(0), 1'b1};
      end
      OP_AWALK: rd_addr = rd_hdr.next;
      OP_TAKE: begin
        wr_en   = !a_prev_start;
        wr_addr = a_prev;
        wr_hdr  = {a_prev_hdr.size, a_prev_hdr.alloc, a_hdr.next, 1'b0};
      end
      OP_TAKE2: begin
        wr_en   = 1'b1;
        wr_addr = a_blk;
        wr_hdr  = {a_fsize, 1'b1, GW'(0), 1'b1};
      end
      OP_RCHK: rd_addr = rel_gran;
      OP_PREW, OP_IWB: begin
        wr_en   = 1'b1;
        wr_addr = i_blk;
        wr_hdr  = i_bh;
      end
      OP_IWALK: rd_addr = rd_hdr.next;
      OP_IDEC:  rd_addr = i_nx;
      OP_IWB2: begin
        wr_en   = 1'b1;
        wr_addr = i_it;
        wr_hdr  = {i_it_hdr.size, i_it_hdr.alloc, i_blk, 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head <= '0;
      free_cnt  <= END_BYTES;
      min_cnt   <= END_BYTES;
      alloc_cnt <= '0;
      rel_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.op == OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (ctl.op)
        OP_TAKE: begin
          if (a_prev_start) begin
            list_head <= a_hdr.next;
          end
          free_cnt  <= free_cnt - gran_bytes(a_fsize);
          alloc_cnt <= alloc_cnt + 32'd1;
        end
        OP_TAKE2: begin
          if (free_cnt < min_cnt) begin
            min_cnt <= free_cnt;
          end
        end
        OP_RRD: begin
          if (sts.rel_ok) begin
            free_cnt <= free_cnt + gran_bytes(rd_hdr.size);
            rel_cnt  <= rel_cnt + 32'd1;
          end
        end
        OP_IWB: begin
          if (!i_merged && i_it_start) begin
            list_head <= i_blk;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        kind_r      <= cmd.kind;
        req_r       <= cmd.request_bytes;
        rel_r       <= cmd.release_offset;
        res_status  <= ST_OK;
        res_payload <= '0;
      end
      OP_DIV: begin
        q <= div_align((kind_r == KIND_RELEASE) ? QN'(rel_r) :
                       QN'(req_r) + QN'(HDR_BYTES + ALIGN_BYTES - 1));
      end
      OP_ACHK: begin
        a_blk        <= list_head;
        a_prev_start <= 1'b1;
        if (sts.zero) begin
          res_status <= ST_ZERO;
        end else if (sts.no_room) begin
          res_status <= ST_NOMEM;
        end
      end
      OP_AWALK: begin
        a_hdr <= rd_hdr;
        if (sts.walk_go) begin
          a_prev       <= a_blk;
          a_prev_hdr   <= rd_hdr;
          a_prev_start <= 1'b0;
          a_blk        <= rd_hdr.next;
        end else if (!sts.walk_fit) begin
          res_status <= ST_NOMEM;
        end
      end
      OP_TAKE: begin
        res_payload <= 12'(gran_bytes(a_blk) + BW'(HDR_BYTES));
      end
      OP_TAKE2: begin
        i_blk <= a_blk + GW'(q);
        i_bh  <= {a_diff, 1'b0, GW'(0), 1'b1};
      end
      OP_RCHK: begin
        i_blk <= rel_gran;
        if (sts.zero) begin
          res_status <= ST_NULL;
        end else if (sts.rel_bad) begin
          res_status <= ST_NOTALLOC;
        end
      end
      OP_RRD: begin
        if (sts.rel_ok) begin
          i_bh <= {rd_hdr.size, 1'b0, rd_hdr.next, rd_hdr.nul};
        end else begin
          res_status <= ST_NOTALLOC;
        end
      end
      OP_ISTART: begin
        i_it_start <= !sts.ins_first;
        i_it       <= list_head;
      end
      OP_IWALK: begin
        i_it_hdr <= rd_hdr;
        if (sts.ins_go) begin
          i_it <= rd_hdr.next;
        end
      end
      OP_IMERGE: begin
        i_merged <= back;
        i_nx     <= ins_nx;
        if (back) begin
          i_blk <= i_it;
          i_bh  <= {i_it_hdr.size + i_bh.size, i_it_hdr.alloc, i_it_hdr.next, i_it_hdr.nul};
        end
      end
      OP_IDEC: begin
        if (!sts.fwd) begin
          i_bh.next <= i_nx;
          i_bh.nul  <= 1'b0;
        end
      end
      OP_IFWD: begin
        i_bh.size <= i_bh.size + rd_hdr.size;
        i_bh.next <= rd_hdr.next;
        i_bh.nul  <= 1'b0;
      end
      OP_EMIT: begin
        rsp.status         <= res_status;
        rsp.payload_offset <= res_payload;
        rsp.free_bytes     <= 12'(free_cnt);
        rsp.min_free_bytes <= 12'(min_cnt);
        rsp.alloc_count    <= alloc_cnt;
        rsp.release_count  <= rel_cnt;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
`default_nettype none

// Self-checking bench for the first-fit coalescing heap. The driver offers
// allocate and release words from a queue; the monitor compares each response
// word against a behavioral copy of the allocator kept in this file.
module tb;
  import ffch_pkg::*;

  localparam int GRAN     = 8;
  localparam int HDR      = 8;
  localparam int NGRAN    = 512;
  localparam int ENDG     = 511;
  localparam int HEADG    = NGRAN;   // pseudo node standing for the list head
  localparam int LIMIT    = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  ffch_cmd_t cmd = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  ffch_rsp_t rsp;

  first_fit_coalescing_heap uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Heap model. Headers are kept as separate arrays; index NGRAN stands for
  // the list head pointer so that unlinking the first block is uniform.
  int unsigned blk_size [NGRAN+1];
  bit          blk_used [NGRAN+1];
  int unsigned blk_next [NGRAN+1];
  bit          blk_last [NGRAN+1];
  int unsigned head_blk, free_now, free_low;
  logic [31:0] grants, returns;

  // Offsets currently granted, so releases can target live blocks.
  int unsigned live_offsets[$];

  ffch_cmd_t pending_words[$];
  ffch_rsp_t expected_rsp[$];

  int errors = 0;
  int accepted_cmds = 0;
  int sender_idle_pct = 29, receiver_idle_pct = 52;
  bit hold_receiver = 1'b0;
  bit stim_done = 1'b0;
  bit cmd_taken = 1'b0;

  function automatic int unsigned clamp_ix(int unsigned g);
    return (g <= NGRAN) ? g : HEADG;
  endfunction

  function automatic int unsigned link_of(int unsigned g);
    return (g == HEADG) ? head_blk : blk_next[clamp_ix(g)];
  endfunction

  function automatic void set_link(int unsigned g, int unsigned n);
    if (g == HEADG) begin
      head_blk = n;
    end else begin
      blk_next[clamp_ix(g)] = n;
      blk_last[clamp_ix(g)] = 1'b0;
    end
  endfunction

  // Put a block back in address order and merge with free neighbors.
  function automatic void return_to_list(int unsigned b);
    int unsigned it, guard, nx;
    it = HEADG;
    guard = 0;
    b = clamp_ix(b);
    while (link_of(it) < b && guard <= NGRAN) begin
      it = clamp_ix(link_of(it));
      guard++;
    end
    if (it != HEADG && it + blk_size[it] == b) begin
      blk_size[it] += blk_size[b];
      b = it;
    end
    nx = link_of(it);
    if (b + blk_size[b] == nx) begin
      if (nx != ENDG && nx < NGRAN) begin
        blk_size[b] += blk_size[nx];
        set_link(b, blk_next[nx]);
      end else begin
        set_link(b, ENDG);
      end
    end else begin
      set_link(b, nx);
    end
    if (it != b) set_link(it, b);
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i <= NGRAN; i++) begin
      blk_size[i] = 0; blk_used[i] = 0; blk_next[i] = 0; blk_last[i] = 0;
    end
    blk_size[0] = ENDG;
    blk_next[0] = ENDG;
    blk_last[ENDG] = 1'b1;
    head_blk = 0;
    free_now = ENDG * GRAN;
    free_low = free_now;
    grants = '0;
    returns = '0;
  endfunction

  function automatic ffch_rsp_t heap_apply(ffch_cmd_t c);
    ffch_rsp_t r;
    int unsigned want, wg, prev, b, guard, nb, g;
    r = '0;
    r.status = ST_OK;
    if (c.kind == KIND_ALLOC) begin
      if (c.request_bytes == 0) begin
        r.status = ST_ZERO;
      end else begin
        want = ((c.request_bytes + HDR + GRAN - 1) / GRAN) * GRAN;
        r.status = ST_NOMEM;
        if (want <= free_now) begin
          wg = want / GRAN;
          prev = HEADG;
          b = clamp_ix(head_blk);
          guard = 0;
          while (blk_size[b] < wg && !blk_last[b] && guard <= NGRAN) begin
            prev = b;
            b = clamp_ix(blk_next[b]);
            guard++;
          end
          if (b < ENDG && blk_size[b] >= wg) begin
            r.payload_offset = 12'(b * GRAN + HDR);
            set_link(prev, blk_next[b]);
            if (blk_size[b] - wg > 2) begin
              nb = clamp_ix(b + wg);
              blk_size[nb] = blk_size[b] - wg;
              blk_used[nb] = 1'b0;
              blk_size[b] = wg;
              return_to_list(nb);
            end
            free_now -= blk_size[b] * GRAN;
            if (free_now < free_low) free_low = free_now;
            blk_used[b] = 1'b1;
            blk_next[b] = 0;
            blk_last[b] = 1'b1;
            grants++;
            r.status = ST_OK;
          end
        end
      end
    end else begin
      if (c.release_offset == 0) begin
        r.status = ST_NULL;
      end else if (c.release_offset < HDR || (c.release_offset % GRAN) != 0 ||
                   (c.release_offset - HDR) / GRAN >= ENDG) begin
        r.status = ST_NOTALLOC;
      end else begin
        g = (c.release_offset - HDR) / GRAN;
        if (blk_used[g] && blk_last[g]) begin
          blk_used[g] = 1'b0;
          free_now += blk_size[g] * GRAN;
          return_to_list(g);
          returns++;
        end else begin
          r.status = ST_NOTALLOC;
        end
      end
    end
    r.free_bytes = 12'(free_now);
    r.min_free_bytes = 12'(free_low);
    r.alloc_count = grants;
    r.release_count = returns;
    return r;
  endfunction

  // A release is only legal on an offset whose header has been written at
  // some point: live or formerly live payloads, the first block, or offsets
  // the model rejects before reading the header. Offsets of granted blocks
  // are tracked here when the word is generated.
  bit header_seen [NGRAN];

  function automatic ffch_cmd_t make_alloc(int unsigned bytes);
    ffch_cmd_t c;
    c = '0;
    c.kind = KIND_ALLOC;
    c.request_bytes = 12'(bytes);
    c.release_offset = 12'($urandom);
    return c;
  endfunction

  function automatic ffch_cmd_t make_release(int unsigned off);
    ffch_cmd_t c;
    c = '0;
    c.kind = KIND_RELEASE;
    c.release_offset = 12'(off);
    c.request_bytes = 12'($urandom);
    return c;
  endfunction

  // Shadow of the model used only while generating, so the generator knows
  // which offsets are live and which headers exist. Generation runs ahead of
  // the driver, so the model is advanced here when each word is queued, not
  // when the driver sends it.
  // To keep it simple the generator predicts in place and records expected
  // responses immediately; the driver sends words in the same order.
  task automatic queue_word(ffch_cmd_t c);
    ffch_rsp_t r;
    int unsigned g;
    r = heap_apply(c);
    if (c.kind == KIND_ALLOC && r.status == ST_OK) begin
      live_offsets.push_back(r.payload_offset);
    end
    // Every block boundary that now exists has a written header.
    g = head_blk;
    for (int i = 0; i < NGRAN && g < ENDG; i++) begin
      header_seen[g] = 1'b1;
      g = blk_next[g];
    end
    if (c.kind == KIND_ALLOC && r.status == ST_OK)
      header_seen[(r.payload_offset - HDR) / GRAN] = 1'b1;
    pending_words.push_back(c);
    expected_rsp.push_back(r);
  endtask

  // Pick a release target: mostly a live block, sometimes a stale or bogus
  // offset, always one the block is allowed to see.
  task automatic queue_release();
    int unsigned pick, off, g;
    pick = $urandom_range(0, 99);
    if (pick < 75 && live_offsets.size() > 0) begin
      g = $urandom_range(0, live_offsets.size() - 1);
      off = live_offsets[g];
      live_offsets.delete(g);
    end else if (pick < 80) begin
      off = 0;
    end else if (pick < 90) begin
      off = $urandom_range(1, 4095);
      g = (off - HDR) / GRAN;
      if (off >= HDR && off % GRAN == 0 && g < ENDG && !header_seen[g])
        off = off | 1;
    end else begin
      off = 0;
      for (int i = 0; i < 8 && off == 0; i++) begin
        g = $urandom_range(0, ENDG - 1);
        if (header_seen[g]) off = g * GRAN + HDR;
      end
      if (off == 0) off = 4095;
    end
    queue_word(make_release(off));
  endtask

  task automatic queue_random_alloc();
    int unsigned r, bytes;
    r = $urandom_range(0, 99);
    if (r < 3) bytes = 0;
    else if (r < 80) bytes = $urandom_range(1, 120);
    else if (r < 95) bytes = $urandom_range(121, 600);
    else bytes = $urandom_range(601, 4095);
    queue_word(make_alloc(bytes));
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 52) queue_random_alloc();
      else queue_release();
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_rsp.size() > 0) @(posedge clk);
  endtask

  // Driver: offer the head of the queue, changing only at the falling edge.
  // A word stays on the bus until the edge that accepts it.
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (pending_words.size() > 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        cmd_valid <= 1'b1;
        cmd <= pending_words[0];
      end else begin
        cmd_valid <= 1'b0;
        cmd <= $bits(ffch_cmd_t)'($urandom);
      end
    end
  end

  // Consume the offered word at the rising edge it is accepted.
  always @(posedge clk) begin
    cmd_taken <= !rst && cmd_valid && !cmd_stall;
    if (!rst && cmd_valid && !cmd_stall) begin
      void'(pending_words.pop_front());
      accepted_cmds++;
    end
  end

  // Receiver stall, either random or held during a backpressure stretch.
  always @(negedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= hold_receiver || ($urandom_range(0, 99) < receiver_idle_pct);
  end

  // Monitor: compare each accepted response word with the oldest prediction.
  always @(posedge clk) begin
    ffch_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected response word %h", rsp);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp !== want) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: status %0d/%0d off %0d/%0d free %0d/%0d min %0d/%0d a %0d/%0d r %0d/%0d",
                     want.status, rsp.status, want.payload_offset, rsp.payload_offset,
                     want.free_bytes, rsp.free_bytes, want.min_free_bytes,
                     rsp.min_free_bytes, want.alloc_count, rsp.alloc_count,
                     want.release_count, rsp.release_count);
        end
      end
    end
  end

  // Watchdog: cycles without any handshake on either side.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned hold;
    heap_reset();
    for (int i = 0; i < NGRAN; i++) header_seen[i] = 1'b0;
    header_seen[0] = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: zero size, largest fit, too large, null, bad offsets,
    // release of an unallocated block, double release, merges both ways.
    queue_word(make_alloc(0));
    queue_word(make_alloc(4095));
    queue_word(make_alloc(4080));
    queue_release();
    queue_word(make_release(0));
    queue_word(make_release(4095));
    queue_word(make_release(4));
    queue_word(make_release(12));
    queue_word(make_release(8));
    queue_word(make_alloc(1));
    queue_word(make_alloc(16));
    queue_word(make_alloc(24));
    queue_word(make_alloc(8));
    queue_word(make_release(8));
    queue_word(make_release(8));
    queue_word(make_release(48));
    queue_word(make_release(24));
    queue_word(make_alloc(4095));
    queue_word(make_alloc(2048));
    queue_word(make_alloc(2048));
    queue_word(make_release(8));
    live_offsets.delete();
    for (int i = 0; i < NGRAN; i++) if (blk_used[i]) live_offsets.push_back(i * GRAN + HDR);

    // Phase one: slow sender, busy receiver.
    queue_random(300);
    wait_drained();

    // Receiver holds off for a long stretch while the sender keeps offering.
    sender_idle_pct = 0;
    queue_random(60);
    hold_receiver = 1'b1;
    for (hold = 0; hold < 400; hold++) @(posedge clk);
    hold_receiver = 1'b0;
    wait_drained();

    // Phase two: roles swapped, then no idling at all.
    sender_idle_pct = 52;
    receiver_idle_pct = 29;
    queue_random(280);
    wait_drained();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    queue_random(290);
    wait_drained();
    repeat (200) @(posedge clk);

    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
